### rtl/mtm_pkg.sv
`default_nettype none
package mtm_pkg;

	// field widths fixed by the item format
	localparam int CHAN_W = 6;
	localparam int LIMIT_W = 8;
	localparam int USE_W = 7;
	localparam int STALE_W = 8;

	// register reset values
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd38;
	localparam logic [USE_W-1:0] USE_RESET = 7'd64;

	// stale counter saturation point
	localparam logic [STALE_W-1:0] STALE_MAX = 8'hFF;

	// register map, selected by paddr[2]
	localparam logic REG_ERROR_LIMIT = 1'b0;
	localparam logic REG_CHANNELS_IN_USE = 1'b1;

	// input item codes
	localparam logic MODE_RECEIVE = 1'b0;
	localparam logic MODE_CHECK = 1'b1;

	// command passed from front to back
	typedef struct packed {
		logic is_check;
		logic [CHAN_W-1:0] channel;
	} cmd_t;

	// back end sequencer
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RX,
		BK_SCAN
	} bk_state_t;

endpackage
`default_nettype wire

### rtl/mtm_front.sv
`default_nettype none
module mtm_front #(
	parameter int CHANNELS = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic mode,
	input wire logic [mtm_pkg::CHAN_W-1:0] channel,
	output logic push_valid,
	output mtm_pkg::cmd_t push_cmd,
	input wire logic queue_full
);

	logic vld_s1;
	mtm_pkg::cmd_t cmd_s1;
	logic keep;
	logic accept;

	// receives on channels that do not exist are dropped here
	assign keep = (mode == mtm_pkg::MODE_CHECK) ||
		({3'b000, channel} < 9'(CHANNELS));

	assign push_valid = vld_s1;
	assign push_cmd = cmd_s1;
	assign in_stall = vld_s1 && queue_full;
	assign accept = in_valid && !in_stall;

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= keep;
		end else if (vld_s1 && !queue_full) begin
			vld_s1 <= 1'b0;
		end
	end

	// classified command
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.is_check <= (mode == mtm_pkg::MODE_CHECK);
			cmd_s1.channel <= channel;
		end
	end

endmodule
`default_nettype wire

### rtl/mtm_queue.sv
`default_nettype none
module mtm_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire mtm_pkg::cmd_t push_cmd,
	output logic full,
	input wire logic pop,
	output logic head_valid,
	output mtm_pkg::cmd_t head_cmd
);

	mtm_pkg::cmd_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_cmd = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

### rtl/mtm_back.sv
`default_nettype none
module mtm_back #(
	parameter int CHANNELS = 64,
	parameter int COUNT_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [mtm_pkg::LIMIT_W-1:0] error_limit,
	input wire logic [mtm_pkg::USE_W-1:0] channels_in_use,
	input wire logic q_valid,
	input wire mtm_pkg::cmd_t q_cmd,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic healthy,
	output logic fault_found,
	output logic [mtm_pkg::CHAN_W-1:0] fault_channel
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(CHANNELS + 1);
	localparam int SW = mtm_pkg::STALE_W;
	localparam int ROW_W = 2 * COUNT_BITS + SW;

	mtm_pkg::bk_state_t state_q, state_d;

	// per-channel row: received, seen, stale
	logic [ROW_W-1:0] mem [CHANNELS];
	logic [CHANNELS-1:0] valid_q;
	logic [ROW_W-1:0] rd_row_q;
	logic rd_hit_q;

	logic [CNT_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] n_lim;
	logic ev_vld_s1;
	logic [IDX_W-1:0] ev_idx_s1;
	logic [IDX_W-1:0] rx_addr_q;
	logic healthy_q;
	logic out_valid_q;
	logic fault_found_q;
	logic [mtm_pkg::CHAN_W-1:0] fault_channel_q;

	logic rd_en;
	logic scan_rd;
	logic [IDX_W-1:0] rd_addr;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [ROW_W-1:0] wr_row;
	logic scan_done;
	logic pop_rx;
	logic pop_chk;

	logic [COUNT_BITS-1:0] rec;
	logic [COUNT_BITS-1:0] seen;
	logic [SW-1:0] stale;
	logic same;
	logic [SW-1:0] stale_inc;
	logic ev_found;
	logic hold;
	logic [ROW_W-1:0] rx_row;
	logic [ROW_W-1:0] scan_row;
	logic [8:0] use_w;

	// channels to scan, capped at the channel count
	assign use_w = {2'b00, channels_in_use};
	assign n_lim = (use_w > 9'(CHANNELS)) ? CNT_W'(CHANNELS) : CNT_W'(use_w);

	// unwritten rows read as zero
	assign rec = rd_hit_q ? rd_row_q[ROW_W-1 -: COUNT_BITS] : '0;
	assign seen = rd_hit_q ? rd_row_q[SW +: COUNT_BITS] : '0;
	assign stale = rd_hit_q ? rd_row_q[SW-1:0] : '0;

	// channel check
	assign same = (rec == seen);
	assign stale_inc = (same && stale != mtm_pkg::STALE_MAX) ? stale + SW'(1) : stale;
	assign ev_found = ev_vld_s1 && (stale_inc >= error_limit);
	assign hold = same || ev_found;
	assign scan_row = {rec, hold ? seen : rec, hold ? stale_inc : SW'(0)};
	assign rx_row = {rec + COUNT_BITS'(1), seen, stale};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mtm_pkg::BK_IDLE: begin
				if (pop_rx) begin
					state_d = mtm_pkg::BK_RX;
				end else if (pop_chk) begin
					state_d = mtm_pkg::BK_SCAN;
				end
			end
			mtm_pkg::BK_RX: begin
				state_d = mtm_pkg::BK_IDLE;
			end
			mtm_pkg::BK_SCAN: begin
				if (scan_done) begin
					state_d = mtm_pkg::BK_IDLE;
				end
			end
			default: state_d = mtm_pkg::BK_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		q_pop = 1'b0;
		pop_rx = 1'b0;
		pop_chk = 1'b0;
		rd_en = 1'b0;
		scan_rd = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_row = rx_row;
		scan_done = 1'b0;
		case (state_q)
			mtm_pkg::BK_IDLE: begin
				if (q_valid && !q_cmd.is_check) begin
					q_pop = 1'b1;
					pop_rx = 1'b1;
					rd_en = 1'b1;
					rd_addr = IDX_W'(q_cmd.channel);
				end else if (q_valid && !out_valid_q) begin
					q_pop = 1'b1;
					pop_chk = 1'b1;
				end
			end
			mtm_pkg::BK_RX: begin
				wr_en = 1'b1;
				wr_addr = rx_addr_q;
				wr_row = rx_row;
			end
			mtm_pkg::BK_SCAN: begin
				if (ev_vld_s1) begin
					wr_en = 1'b1;
					wr_addr = ev_idx_s1;
					wr_row = scan_row;
				end
				if (rd_idx_q != n_q && !ev_found) begin
					rd_en = 1'b1;
					scan_rd = 1'b1;
					rd_addr = rd_idx_q[IDX_W-1:0];
				end
				scan_done = (rd_idx_q == n_q) || ev_found;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtm_pkg::BK_IDLE;
			valid_q <= '0;
			rd_hit_q <= 1'b0;
			rd_idx_q <= '0;
			n_q <= '0;
			ev_vld_s1 <= 1'b0;
			healthy_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= valid_q[rd_addr];
			end
			if (pop_chk) begin
				rd_idx_q <= '0;
				n_q <= n_lim;
			end else if (scan_rd) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			ev_vld_s1 <= scan_rd;
			if (scan_done && ev_found) begin
				healthy_q <= 1'b0;
			end
			if (scan_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// counter memory and payload registers
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= mem[rd_addr];
		end
		if (scan_rd) begin
			ev_idx_s1 <= rd_addr;
		end
		if (pop_rx) begin
			rx_addr_q <= IDX_W'(q_cmd.channel);
		end
		if (scan_done) begin
			fault_found_q <= ev_found;
			fault_channel_q <= ev_found ? mtm_pkg::CHAN_W'(ev_idx_s1) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign healthy = healthy_q;
	assign fault_found = fault_found_q;
	assign fault_channel = fault_channel_q;

endmodule
`default_nettype wire

### rtl/message_timeout_monitor_unit.sv
`default_nettype none
// Message timeout watchdog over CHANNELS channels. A receive transfer (mode 0)
// bumps that channel's message count and gives no result; a check transfer
// (mode 1) walks channels 0 .. n-1, with n = channels_in_use capped at CHANNELS,
// and returns one result with the sticky healthy flag and the first channel
// whose stale count reached error_limit. The per-channel counts live in one
// memory that the back end reads and writes back one channel per cycle; a
// check holds the back end until it has walked all n channels or stopped at
// the first faulty channel, and a receive holds it for one read and one
// write-back. An input stage and a two-entry command queue sit in front of
// the back end: receives keep draining while a result waits at the output, a
// check waits at the queue head until the output is free, and the input stalls
// once the stage and both queue entries are full.
// Registers: 0x0 error_limit (reset 38), 0x4 channels_in_use (reset 64).
module message_timeout_monitor_unit #(
	parameter int CHANNELS = 64,
	parameter int COUNT_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic mode,
	input wire logic [mtm_pkg::CHAN_W-1:0] channel,
	output logic out_valid,
	input wire logic out_stall,
	output logic healthy,
	output logic fault_found,
	output logic [mtm_pkg::CHAN_W-1:0] fault_channel
);

	logic [mtm_pkg::LIMIT_W-1:0] error_limit_q;
	logic [mtm_pkg::USE_W-1:0] channels_in_use_q;
	logic cfg_wr;
	logic push_valid;
	mtm_pkg::cmd_t push_cmd;
	logic queue_full;
	logic q_valid;
	mtm_pkg::cmd_t q_cmd;
	logic q_pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_limit_q <= mtm_pkg::LIMIT_RESET;
			channels_in_use_q <= mtm_pkg::USE_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				mtm_pkg::REG_ERROR_LIMIT: error_limit_q <= pwdata[mtm_pkg::LIMIT_W-1:0];
				mtm_pkg::REG_CHANNELS_IN_USE: channels_in_use_q <= pwdata[mtm_pkg::USE_W-1:0];
				default: error_limit_q <= error_limit_q;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[2])
			mtm_pkg::REG_ERROR_LIMIT: prdata = {24'd0, error_limit_q};
			mtm_pkg::REG_CHANNELS_IN_USE: prdata = {25'd0, channels_in_use_q};
			default: prdata = '0;
		endcase
	end

	mtm_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.channel(channel),
		.push_valid(push_valid),
		.push_cmd(push_cmd),
		.queue_full(queue_full)
	);

	mtm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push_valid),
		.push_cmd(push_cmd),
		.full(queue_full),
		.pop(q_pop),
		.head_valid(q_valid),
		.head_cmd(q_cmd)
	);

	mtm_back #(
		.CHANNELS(CHANNELS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.error_limit(error_limit_q),
		.channels_in_use(channels_in_use_q),
		.q_valid(q_valid),
		.q_cmd(q_cmd),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.healthy(healthy),
		.fault_found(fault_found),
		.fault_channel(fault_channel)
	);

endmodule
`default_nettype wire
